[rtl/lcs_pkg.sv]
// shared types, widths and constants of the lba to chs read splitter
package lcs_pkg;

  localparam int START_W     = 64;
  localparam int COUNT_W     = 7;
  localparam int WORD_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int SPT_W       = 6;
  localparam int HEADS_W     = 9;
  localparam int CYLS_W      = 11;
  localparam int PCYL_W      = 14;
  localparam int TOTAL_W     = 25;
  localparam int CHS_LBA_W   = 32;
  localparam int DVD_W       = 24;
  localparam int CYL_W       = 10;
  localparam int SHORT_ITERS = PCYL_W;
  localparam int LONG_ITERS  = DVD_W;
  localparam int ITER_W      = $clog2(LONG_ITERS + 1);

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  localparam int MAX_SECTORS_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [BYTE_W-1:0]  DRIVE_RESET = 8'd128;
  localparam logic [CYLS_W-1:0]  QUIRK_CYLS  = 11'd81;
  localparam logic [SPT_W-1:0]   QUIRK_SPT   = 6'd18;
  localparam logic [HEADS_W-1:0] QUIRK_HEADS = 9'd3;
  localparam logic [CYLS_W-1:0]  FIXED_CYLS  = 11'd80;
  localparam logic [HEADS_W-1:0] FIXED_HEADS = 9'd2;

  typedef enum logic [1:0] {
    REG_GEOMETRY_CX  = 2'd0,
    REG_GEOMETRY_DH  = 2'd1,
    REG_DRIVE_NUMBER = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_CHS = 2'd0,
    KIND_EXT = 2'd1,
    KIND_ERR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] geometry_cx;
    logic [BYTE_W-1:0] geometry_dh;
    logic [BYTE_W-1:0] drive_number;
  } cfg_regs_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [START_W-1:0]   lba;
    logic [COUNT_W-1:0]   num;
    logic [SPT_W-1:0]     spt;
    logic [HEADS_W-1:0]   heads;
    logic [PCYL_W-1:0]    per_cyl;
    logic [BYTE_W-1:0]    drive;
  } req_t;

endpackage

[rtl/lcs_front.sv]
// front end: accepts requests, decodes geometry and classifies each request
module lcs_front #(
  parameter int MAX_SECTORS = lcs_pkg::MAX_SECTORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lcs_pkg::cfg_regs_t              cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lcs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            push_valid,
  output lcs_pkg::req_t                   push_req,
  input  logic                            q_full
);
  import lcs_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SECTORS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_CMP  = 3'b100
  } front_state_t;

  front_state_t         state_r, state_nxt;
  logic [START_W-1:0]   start_r;
  logic [COUNT_W-1:0]   num_r;
  logic [CYLS_W-1:0]    cyls_r;
  logic [SPT_W-1:0]     spt_r;
  logic [HEADS_W-1:0]   heads_r;
  logic [PCYL_W-1:0]    pcyl_r;

  logic [COUNT_W-1:0]   cnt_in, cnt_sat;
  logic [CYLS_W-1:0]    cyls_raw, cyls_g;
  logic [SPT_W-1:0]     spt_g;
  logic [HEADS_W-1:0]   heads_raw, heads_g;
  logic [TOTAL_W-1:0]   total;
  logic [CHS_LBA_W:0]   span_end;
  logic                 reaches_end;
  logic                 accept;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cnt_in    = in_tdata[START_W +: COUNT_W];
  assign cnt_sat   = (cnt_in > MAX_CNT) ? MAX_CNT : cnt_in;

  // geometry decode with the 81/18/3 correction
  always_comb begin
    cyls_raw  = {3'b000, cfg.geometry_cx[15:8]} + {1'b0, cfg.geometry_cx[7:6], 8'h00}
                + CYLS_W'(1);
    spt_g     = cfg.geometry_cx[SPT_W-1:0];
    heads_raw = {1'b0, cfg.geometry_dh} + HEADS_W'(1);
    if (cyls_raw == QUIRK_CYLS && spt_g == QUIRK_SPT && heads_raw == QUIRK_HEADS) begin
      cyls_g  = FIXED_CYLS;
      heads_g = FIXED_HEADS;
    end else begin
      cyls_g  = cyls_raw;
      heads_g = heads_raw;
    end
  end

  assign total       = TOTAL_W'(pcyl_r * cyls_r);
  assign span_end    = {1'b0, start_r[CHS_LBA_W-1:0]} + {{(CHS_LBA_W+1-COUNT_W){1'b0}}, num_r};
  assign reaches_end = span_end >= {{(CHS_LBA_W+1-TOTAL_W){1'b0}}, total};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && cnt_sat != '0) state_nxt = F_MUL;
      end
      F_MUL: state_nxt = F_CMP;
      F_CMP: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= in_tdata[START_W-1:0];
      num_r   <= cnt_sat;
    end
    if (state_r == F_MUL) begin
      cyls_r  <= cyls_g;
      spt_r   <= spt_g;
      heads_r <= heads_g;
      pcyl_r  <= PCYL_W'(heads_g * spt_g);
    end
  end

  assign push_valid = (state_r == F_CMP) && !q_full;

  always_comb begin
    push_req.lba     = start_r;
    push_req.num     = num_r;
    push_req.spt     = spt_r;
    push_req.heads   = heads_r;
    push_req.per_cyl = pcyl_r;
    push_req.drive   = cfg.drive_number;
    if (spt_r == '0)      push_req.kind = KIND_ERR;
    else if (reaches_end) push_req.kind = KIND_EXT;
    else                  push_req.kind = KIND_CHS;
  end

endmodule

[rtl/lcs_queue.sv]
// short request queue between the front end and the command sequencer
module lcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcs_pkg::req_t push_req,
  input  logic          pop,
  output lcs_pkg::req_t pop_req,
  output logic          full,
  output logic          empty
);
  import lcs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  req_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_req = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_req;
  end

endmodule

[rtl/lcs_div.sv]
// serial restoring divider, one quotient bit per cycle
module lcs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        short_mode,
  input  logic [lcs_pkg::DVD_W-1:0]   dividend,
  input  logic [lcs_pkg::PCYL_W-1:0]  divisor,
  output logic                        done,
  output logic [lcs_pkg::DVD_W-1:0]   quotient,
  output logic [lcs_pkg::PCYL_W-1:0]  remainder
);
  import lcs_pkg::*;

  logic                busy_r, done_r;
  logic [ITER_W-1:0]   iter_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [PCYL_W-1:0]   rem_r, dvr_r;
  logic [PCYL_W:0]     trial, diff;
  logic                fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvr_r};
  assign fits  = trial >= {1'b0, dvr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= short_mode ? ITER_W'(SHORT_ITERS) : ITER_W'(LONG_ITERS);
      end else if (busy_r) begin
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvr_r <= divisor;
      // short operands sit at the top so fewer steps are needed
      dvd_r <= short_mode ? {dividend[SHORT_ITERS-1:0], {(DVD_W-SHORT_ITERS){1'b0}}}
                          : dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[PCYL_W-1:0] : trial[PCYL_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

[rtl/lcs_back.sv]
// command sequencer: splits requests into track chunks and drives the result register
module lcs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  lcs_pkg::req_t                   q_req,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);
  import lcs_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV1 = 5'b00010,
    B_DIV2 = 5'b00100,
    B_EMIT = 5'b01000,
    B_ONE  = 5'b10000
  } back_state_t;

  back_state_t          state_r, state_nxt;
  req_t                 req_r;
  logic [CYLS_W-1:0]    c_r, c_nxt;
  logic [BYTE_W-1:0]    h_r, h_nxt;
  logic [SPT_W-1:0]     s_r, s_nxt;
  logic [COUNT_W-1:0]   num_r, num_nxt;

  logic                 out_valid_r;
  cmd_kind_t            out_kind_r, o_kind;
  logic [WORD_W-1:0]    out_cx_r, out_dx_r, o_cx, o_dx;
  logic [START_W-1:0]   out_lba_r, o_lba;
  logic [COUNT_W-1:0]   out_n_r, o_n;
  logic                 out_last_r, o_last;
  logic                 load_out, out_free;

  logic                 div_start, div_short, div_done;
  logic [DVD_W-1:0]     div_dvd, div_quo;
  logic [PCYL_W-1:0]    div_dvr, div_rem;

  logic [COUNT_W-1:0]   avail, n_chunk, num_left;
  logic [HEADS_W-1:0]   h_inc;

  lcs_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .short_mode (div_short),
    .dividend   (div_dvd),
    .divisor    (div_dvr),
    .done       (div_done),
    .quotient   (div_quo),
    .remainder  (div_rem)
  );

  assign out_free = !out_valid_r || out_tready;
  assign avail    = {1'b0, req_r.spt} - {1'b0, s_r} + COUNT_W'(1);
  assign n_chunk  = (num_r > avail) ? avail : num_r;
  assign num_left = num_r - n_chunk;
  assign h_inc    = {1'b0, h_r} + HEADS_W'(1);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_short = 1'b0;
    div_dvd   = q_req.lba[DVD_W-1:0];
    div_dvr   = q_req.per_cyl;
    c_nxt     = c_r;
    h_nxt     = h_r;
    s_nxt     = s_r;
    num_nxt   = num_r;
    load_out  = 1'b0;
    o_kind    = KIND_CHS;
    o_cx      = '0;
    o_dx      = '0;
    o_lba     = '0;
    o_n       = '0;
    o_last    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          num_nxt = q_req.num;
          if (q_req.kind == KIND_CHS) begin
            div_start = 1'b1;
            state_nxt = B_DIV1;
          end else begin
            state_nxt = B_ONE;
          end
        end
      end
      B_DIV1: begin
        div_dvd = {{(DVD_W-PCYL_W){1'b0}}, div_rem};
        div_dvr = {{(PCYL_W-SPT_W){1'b0}}, req_r.spt};
        if (div_done) begin
          if (div_quo[DVD_W-1:CYL_W] != '0) begin
            // cylinder out of range, flagged through the top cylinder bit
            c_nxt     = {1'b1, {CYL_W{1'b0}}};
            state_nxt = B_EMIT;
          end else begin
            c_nxt     = {1'b0, div_quo[CYL_W-1:0]};
            div_start = 1'b1;
            div_short = 1'b1;
            state_nxt = B_DIV2;
          end
        end
      end
      B_DIV2: begin
        if (div_done) begin
          h_nxt     = div_quo[BYTE_W-1:0];
          s_nxt     = div_rem[SPT_W-1:0] + SPT_W'(1);
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (c_r[CYLS_W-1]) begin
            o_kind    = KIND_ERR;
            o_last    = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            o_kind  = KIND_CHS;
            o_cx    = {c_r[7:0], c_r[9:8], s_r};
            o_dx    = {h_r, req_r.drive};
            o_n     = n_chunk;
            o_last  = (num_left == '0);
            num_nxt = num_left;
            s_nxt   = SPT_W'(1);
            if (h_inc == req_r.heads) begin
              h_nxt = '0;
              c_nxt = c_r + CYLS_W'(1);
            end else begin
              h_nxt = h_inc[BYTE_W-1:0];
            end
            if (num_left == '0) state_nxt = B_IDLE;
          end
        end
      end
      B_ONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          o_last    = 1'b1;
          state_nxt = B_IDLE;
          if (req_r.kind == KIND_EXT) begin
            o_kind = KIND_EXT;
            o_dx   = {{BYTE_W{1'b0}}, req_r.drive};
            o_lba  = req_r.lba;
            o_n    = num_r;
          end else begin
            o_kind = KIND_ERR;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_req;
    c_r   <= c_nxt;
    h_r   <= h_nxt;
    s_r   <= s_nxt;
    num_r <= num_nxt;
    if (load_out) begin
      out_kind_r <= o_kind;
      out_cx_r   <= o_cx;
      out_dx_r   <= o_dx;
      out_lba_r  <= o_lba;
      out_n_r    <= o_n;
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_n_r, out_lba_r, out_dx_r, out_cx_r};

  a_chs_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_CHS |-> out_n_r != '0 && out_lba_r == '0)
    else $error("chs chunk with no sectors or a stray lba");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_ERR |-> out_last_r && out_n_r == '0 && out_dx_r == '0)
    else $error("error item not final or not cleared");

  a_ext_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_EXT |-> out_last_r && out_cx_r == '0)
    else $error("extended read not a single final item");

endmodule

[rtl/lba_to_chs_read_splitter_top.sv]
// top level of the lba to chs read splitter: configuration registers and wiring
//
// in_* is a stream of read requests: in_tdata holds start_sector in bits 63:0
// and sector_count in bits 70:64. out_* is a stream of commands, one item per
// command, with tlast on the final item of a request and the command kind
// (chs chunk, extended read, error) in tuser. cfg_* writes geometry_cx,
// geometry_dh and drive_number at indexes 0, 1 and 2; it is always ready and
// should only be used while no request is in flight.
// The front end takes a new request only after it has pushed the previous one,
// and waits while its queue is full. A chs request leaves the queue, passes the
// cylinder division (24 divider steps) and the head/sector division (14 steps),
// then issues one chunk item per cycle while the receiver is ready.
// Extended reads and errors bypass the divider and produce a single final item.
// A request with a zero count is taken and produces no item.
// Reset clears the queue and sequencers and loads geometry 0/0 and drive 128.
// When the receiver stalls the result register holds its item, the sequencer
// waits and the two entry queue lets the front end keep taking requests.
module lba_to_chs_read_splitter_top #(
  parameter int MAX_SECTORS = lcs_pkg::MAX_SECTORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_sector [63:0], sector_count [70:64]
  input  logic [lcs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cx_word [15:0], dx_word [31:16], lba_address [95:32], chunk_sectors [102:96]
  output logic [lcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // command_kind [1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [lcs_pkg::WORD_W-1:0]      cfg_data
);
  import lcs_pkg::*;

  cfg_regs_t cfg_r;
  req_t      push_req, pop_req;
  logic      push_valid, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.geometry_cx  <= '0;
      cfg_r.geometry_dh  <= '0;
      cfg_r.drive_number <= DRIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GEOMETRY_CX:  cfg_r.geometry_cx  <= cfg_data;
        REG_GEOMETRY_DH:  cfg_r.geometry_dh  <= cfg_data[BYTE_W-1:0];
        REG_DRIVE_NUMBER: cfg_r.drive_number <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  lcs_front #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_req   (push_req),
    .q_full     (q_full)
  );

  lcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_req (push_req),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  lcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_req      (pop_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
